FILE: hw/rtl/ecc_jpad_pkg.sv
package ecc_jpad_pkg;

    localparam int WORDS_DEF = 8;
    localparam int NSLOT     = 17;
    localparam int PC_W      = 7;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_DBL  = 2'd2;

    localparam logic [2:0] TARGET_MOD = 3'd0;

    typedef logic [4:0] t_slot;

    localparam t_slot SL_CA = 5'd0;
    localparam t_slot SL_AX = 5'd1;
    localparam t_slot SL_AY = 5'd2;
    localparam t_slot SL_AZ = 5'd3;
    localparam t_slot SL_BX = 5'd4;
    localparam t_slot SL_BY = 5'd5;
    localparam t_slot SL_BZ = 5'd6;
    localparam t_slot SL_RX = 5'd7;
    localparam t_slot SL_RY = 5'd8;
    localparam t_slot SL_RZ = 5'd9;
    localparam t_slot SL_N0 = 5'd10;
    localparam t_slot SL_N1 = 5'd11;
    localparam t_slot SL_N2 = 5'd12;
    localparam t_slot SL_N3 = 5'd13;
    localparam t_slot SL_N4 = 5'd14;
    localparam t_slot SL_N5 = 5'd15;
    localparam t_slot SL_N6 = 5'd16;

    localparam t_slot FLAG0 = 5'd0;
    localparam t_slot FLAG1 = 5'd1;

    localparam logic [PC_W-1:0] PC_ADD  = 7'd0;
    localparam logic [PC_W-1:0] PC_CPYA = 7'd39;
    localparam logic [PC_W-1:0] PC_CPYB = 7'd43;
    localparam logic [PC_W-1:0] PC_DBL  = 7'd47;

    typedef enum logic [3:0] {
        K_ZT, K_CPY, K_ADD, K_SUB, K_MUL, K_HALF,
        K_BRA1, K_BRA2, K_BRD, K_END, K_ENDA, K_ENDB
    } t_kind;

    typedef enum logic [3:0] {
        C_ALL, C_AZ1, C_NAZ1, C_BZ1, C_NBZ1, C_BOTH, C_NBOTH, C_A_NB, C_NA_B, C_NANB
    } t_cond;

    typedef struct packed {
        t_kind kind;
        t_cond cond;
        t_slot dst;
        t_slot sa;
        t_slot sb;
    } t_instr;

    function automatic t_instr mk(input t_kind k, input t_cond c, input t_slot d,
                                  input t_slot a, input t_slot b);
        t_instr r;
        r.kind = k;
        r.cond = c;
        r.dst  = d;
        r.sa   = a;
        r.sb   = b;
        return r;
    endfunction

    function automatic logic cond_ok(input t_cond c, input logic az1, input logic bz1);
        logic r;
        case (c)
            C_ALL:   r = 1'b1;
            C_AZ1:   r = az1;
            C_NAZ1:  r = !az1;
            C_BZ1:   r = bz1;
            C_NBZ1:  r = !bz1;
            C_BOTH:  r = az1 && bz1;
            C_NBOTH: r = !(az1 && bz1);
            C_A_NB:  r = az1 && !bz1;
            C_NA_B:  r = !az1 && bz1;
            C_NANB:  r = !az1 && !bz1;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr r;
        case (pc)
            // point addition
            7'd0:  r = mk(K_ZT,   C_ALL,   FLAG0, SL_AZ, SL_CA);
            7'd1:  r = mk(K_ZT,   C_ALL,   FLAG1, SL_BZ, SL_CA);
            7'd2:  r = mk(K_BRA1, C_ALL,   SL_CA, SL_CA, SL_CA);
            7'd3:  r = mk(K_CPY,  C_BZ1,   SL_N1, SL_AX, SL_CA);
            7'd4:  r = mk(K_CPY,  C_BZ1,   SL_N2, SL_AY, SL_CA);
            7'd5:  r = mk(K_MUL,  C_NBZ1,  SL_N0, SL_BZ, SL_BZ);
            7'd6:  r = mk(K_MUL,  C_NBZ1,  SL_N1, SL_AX, SL_N0);
            7'd7:  r = mk(K_MUL,  C_NBZ1,  SL_N0, SL_N0, SL_BZ);
            7'd8:  r = mk(K_MUL,  C_NBZ1,  SL_N2, SL_AY, SL_N0);
            7'd9:  r = mk(K_CPY,  C_AZ1,   SL_N3, SL_BX, SL_CA);
            7'd10: r = mk(K_CPY,  C_AZ1,   SL_N4, SL_BY, SL_CA);
            7'd11: r = mk(K_MUL,  C_NAZ1,  SL_N0, SL_AZ, SL_AZ);
            7'd12: r = mk(K_MUL,  C_NAZ1,  SL_N3, SL_BX, SL_N0);
            7'd13: r = mk(K_MUL,  C_NAZ1,  SL_N0, SL_N0, SL_AZ);
            7'd14: r = mk(K_MUL,  C_NAZ1,  SL_N4, SL_BY, SL_N0);
            7'd15: r = mk(K_SUB,  C_ALL,   SL_N5, SL_N1, SL_N3);
            7'd16: r = mk(K_SUB,  C_ALL,   SL_N6, SL_N2, SL_N4);
            7'd17: r = mk(K_ZT,   C_ALL,   FLAG0, SL_N5, SL_CA);
            7'd18: r = mk(K_ZT,   C_ALL,   FLAG1, SL_N6, SL_CA);
            7'd19: r = mk(K_BRA2, C_ALL,   SL_CA, SL_CA, SL_CA);
            7'd20: r = mk(K_ADD,  C_ALL,   SL_N1, SL_N1, SL_N3);
            7'd21: r = mk(K_ADD,  C_ALL,   SL_N2, SL_N2, SL_N4);
            7'd22: r = mk(K_CPY,  C_BOTH,  SL_RZ, SL_N5, SL_CA);
            7'd23: r = mk(K_CPY,  C_A_NB,  SL_N0, SL_BZ, SL_CA);
            7'd24: r = mk(K_CPY,  C_NA_B,  SL_N0, SL_AZ, SL_CA);
            7'd25: r = mk(K_MUL,  C_NANB,  SL_N0, SL_AZ, SL_BZ);
            7'd26: r = mk(K_MUL,  C_NBOTH, SL_RZ, SL_N0, SL_N5);
            7'd27: r = mk(K_MUL,  C_ALL,   SL_N0, SL_N6, SL_N6);
            7'd28: r = mk(K_MUL,  C_ALL,   SL_N4, SL_N5, SL_N5);
            7'd29: r = mk(K_MUL,  C_ALL,   SL_N3, SL_N1, SL_N4);
            7'd30: r = mk(K_SUB,  C_ALL,   SL_RX, SL_N0, SL_N3);
            7'd31: r = mk(K_ADD,  C_ALL,   SL_N0, SL_RX, SL_RX);
            7'd32: r = mk(K_SUB,  C_ALL,   SL_N0, SL_N3, SL_N0);
            7'd33: r = mk(K_MUL,  C_ALL,   SL_N0, SL_N0, SL_N6);
            7'd34: r = mk(K_MUL,  C_ALL,   SL_N5, SL_N4, SL_N5);
            7'd35: r = mk(K_MUL,  C_ALL,   SL_N1, SL_N2, SL_N5);
            7'd36: r = mk(K_SUB,  C_ALL,   SL_N0, SL_N0, SL_N1);
            7'd37: r = mk(K_HALF, C_ALL,   SL_RY, SL_N0, SL_CA);
            7'd38: r = mk(K_END,  C_ALL,   SL_CA, SL_CA, SL_CA);
            // copy A
            7'd39: r = mk(K_CPY,  C_ALL,   SL_RX, SL_AX, SL_CA);
            7'd40: r = mk(K_CPY,  C_ALL,   SL_RY, SL_AY, SL_CA);
            7'd41: r = mk(K_CPY,  C_ALL,   SL_RZ, SL_AZ, SL_CA);
            7'd42: r = mk(K_ENDA, C_ALL,   SL_CA, SL_CA, SL_CA);
            // copy B
            7'd43: r = mk(K_CPY,  C_ALL,   SL_RX, SL_BX, SL_CA);
            7'd44: r = mk(K_CPY,  C_ALL,   SL_RY, SL_BY, SL_CA);
            7'd45: r = mk(K_CPY,  C_ALL,   SL_RZ, SL_BZ, SL_CA);
            7'd46: r = mk(K_ENDB, C_ALL,   SL_CA, SL_CA, SL_CA);
            // point doubling
            7'd47: r = mk(K_ZT,   C_ALL,   FLAG0, SL_AZ, SL_CA);
            7'd48: r = mk(K_BRD,  C_ALL,   SL_CA, SL_CA, SL_CA);
            7'd49: r = mk(K_MUL,  C_ALL,   SL_N0, SL_AX, SL_AX);
            7'd50: r = mk(K_ADD,  C_ALL,   SL_N1, SL_N0, SL_N0);
            7'd51: r = mk(K_ADD,  C_ALL,   SL_N0, SL_N0, SL_N1);
            7'd52: r = mk(K_ADD,  C_AZ1,   SL_N1, SL_N0, SL_CA);
            7'd53: r = mk(K_MUL,  C_NAZ1,  SL_N1, SL_AZ, SL_AZ);
            7'd54: r = mk(K_MUL,  C_NAZ1,  SL_N1, SL_N1, SL_N1);
            7'd55: r = mk(K_MUL,  C_NAZ1,  SL_N1, SL_N1, SL_CA);
            7'd56: r = mk(K_ADD,  C_NAZ1,  SL_N1, SL_N1, SL_N0);
            7'd57: r = mk(K_CPY,  C_AZ1,   SL_N0, SL_AY, SL_CA);
            7'd58: r = mk(K_MUL,  C_NAZ1,  SL_N0, SL_AY, SL_AZ);
            7'd59: r = mk(K_ADD,  C_ALL,   SL_RZ, SL_N0, SL_N0);
            7'd60: r = mk(K_MUL,  C_ALL,   SL_N3, SL_AY, SL_AY);
            7'd61: r = mk(K_MUL,  C_ALL,   SL_N2, SL_AX, SL_N3);
            7'd62: r = mk(K_ADD,  C_ALL,   SL_N2, SL_N2, SL_N2);
            7'd63: r = mk(K_ADD,  C_ALL,   SL_N2, SL_N2, SL_N2);
            7'd64: r = mk(K_ADD,  C_ALL,   SL_N0, SL_N2, SL_N2);
            7'd65: r = mk(K_MUL,  C_ALL,   SL_RX, SL_N1, SL_N1);
            7'd66: r = mk(K_SUB,  C_ALL,   SL_RX, SL_RX, SL_N0);
            7'd67: r = mk(K_MUL,  C_ALL,   SL_N0, SL_N3, SL_N3);
            7'd68: r = mk(K_ADD,  C_ALL,   SL_N3, SL_N0, SL_N0);
            7'd69: r = mk(K_ADD,  C_ALL,   SL_N3, SL_N3, SL_N3);
            7'd70: r = mk(K_ADD,  C_ALL,   SL_N3, SL_N3, SL_N3);
            7'd71: r = mk(K_SUB,  C_ALL,   SL_N0, SL_N2, SL_RX);
            7'd72: r = mk(K_MUL,  C_ALL,   SL_N0, SL_N1, SL_N0);
            7'd73: r = mk(K_SUB,  C_ALL,   SL_RY, SL_N0, SL_N3);
            7'd74: r = mk(K_END,  C_ALL,   SL_CA, SL_CA, SL_CA);
            default: r = mk(K_END, C_ALL,  SL_CA, SL_CA, SL_CA);
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/ecc_jacobian_point_add_double_unit.sv
// a run item's time is set by the shared 32x32 multiplier, which runs each montgomery
//   product, plus operand load and writeback through the word scratch memory with one
//   read and one write port; the result goes out as 3*WORDS words
// one item at a time; load items are taken while idle, run items block input until done
// reset: synchronous active-low clears the sequencer, output valid and mont_n0;
//   operand and scratch memory contents are undefined until written
module ecc_jacobian_point_add_double_unit #(
    parameter int WORDS = ecc_jpad_pkg::WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_target,
    input  logic [2:0]  i_word_index,
    input  logic [31:0] i_load_word,
    input  logic        i_a_z_is_one,
    input  logic        i_b_z_is_one,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_word,
    output logic [1:0]  o_coordinate,
    output logic [2:0]  o_out_index,
    output logic        o_result_z_is_one,
    output logic        o_is_last
);

    localparam int DW     = WORDS * 32;
    localparam int DEPTH  = ecc_jpad_pkg::NSLOT * WORDS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WIDX_W = $clog2(WORDS);
    localparam int CNT_W  = $clog2(WORDS + 1);
    localparam int PC_W   = ecc_jpad_pkg::PC_W;
    localparam logic [1:0] ADDR_MONT_N0 = 2'd0;

    typedef enum logic [4:0] {
        S_IDLE, S_FETCH, S_LDA, S_LDB, S_DISP,
        S_ADD1, S_ADD2, S_SUB1, S_SUB2, S_HALF1, S_HALF2,
        S_MULA, S_MULAH, S_MULM, S_MULB, S_MULBH, S_MULF,
        S_WB, S_ORD, S_OWAIT, S_OHOLD
    } t_state;

    function automatic logic [ADDR_W-1:0] f_addr(input ecc_jpad_pkg::t_slot s,
                                                 input logic [WIDX_W-1:0] w);
        return ADDR_W'(ADDR_W'(s) * ADDR_W'(WORDS)) + ADDR_W'(w);
    endfunction

    t_state                 r_state;
    logic [PC_W-1:0]        r_pc;
    ecc_jpad_pkg::t_instr   r_ins;
    logic [31:0]            r_n0;
    logic [DW-1:0]          r_mod;
    logic [DW-1:0]          r_opa;
    logic [DW-1:0]          r_opb;
    logic [DW-1:0]          r_pr;
    logic [DW-1:0]          r_t;
    logic                   r_tc;
    logic [31:0]            r_th;
    logic                   r_th2;
    logic [31:0]            r_c;
    logic [31:0]            r_m;
    logic [CNT_W-1:0]       r_cnt;
    logic [WIDX_W-1:0]      r_i;
    logic                   r_az1;
    logic                   r_bz1;
    logic                   r_z0;
    logic                   r_z1;
    logic                   r_inf;
    logic                   r_zone;
    logic [1:0]             r_ocoord;
    logic [WIDX_W-1:0]      r_oidx;
    logic [31:0]            r_rdata;
    logic [31:0]            r_mem [DEPTH];
    logic                   r_out_valid;
    logic [31:0]            r_out_word;
    logic [1:0]             r_out_coord;
    logic [WIDX_W-1:0]      r_out_idx;
    logic                   r_out_last;

    ecc_jpad_pkg::t_instr   fetch_ins;
    logic                   in_take;
    logic                   load_ok;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    logic [31:0]            mem_wd;
    logic [31:0]            mul_x;
    logic [31:0]            mul_y;
    logic [63:0]            prod;
    logic [63:0]            mac;
    logic [32:0]            hsum;
    logic [DW:0]            add_sum;
    logic [DW:0]            sub_dif;
    logic [DW+1:0]          red_dif;
    logic [DW:0]            fin_dif;
    logic [DW:0]            half_sum;
    logic [WIDX_W-1:0]      cnt_idx;
    logic                   cnt_last;
    logic [31:0]            oidx_ext;
    logic [31:0]            widx_ext;

    assign pready = 1'b1;
    assign prdata = r_n0;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_take = i_in_valid && !o_in_stall;
    assign fetch_ins = ecc_jpad_pkg::prog(r_pc);
    assign cnt_idx = r_cnt[WIDX_W-1:0];
    assign cnt_last = (r_cnt == CNT_W'(WORDS - 1));
    assign widx_ext = 32'(i_word_index);
    assign load_ok = (widx_ext < 32'(WORDS));

    assign o_out_valid = r_out_valid;
    assign o_result_word = r_out_word;
    assign o_coordinate = r_out_coord;
    assign oidx_ext = 32'(r_out_idx);
    assign o_out_index = oidx_ext[2:0];
    assign o_result_z_is_one = r_zone;
    assign o_is_last = r_out_last;

    // shared word multiplier
    always_comb begin
        case (r_state)
            S_MULM: begin
                mul_x = r_t[31:0];
                mul_y = r_n0;
            end
            S_MULB: begin
                mul_x = r_m;
                mul_y = r_pr[31:0];
            end
            default: begin
                mul_x = r_opa[31:0];
                mul_y = r_opb[31:0];
            end
        endcase
        prod = 64'(mul_x) * 64'(mul_y);
        mac = prod + 64'(r_t[31:0]) + 64'(r_c);
        hsum = 33'(r_th) + 33'(r_c);
    end

    always_comb begin
        add_sum  = {1'b0, r_opa} + {1'b0, r_opb};
        sub_dif  = {1'b0, r_opa} - {1'b0, r_opb};
        red_dif  = {1'b0, r_tc, r_t} - {2'b00, r_mod};
        fin_dif  = {1'b0, r_t} - {1'b0, r_mod};
        half_sum = {1'b0, r_opa} + (r_opa[0] ? {1'b0, r_mod} : {(DW + 1){1'b0}});
    end

    always_comb begin
        case (r_state)
            S_LDA:   rd_addr = f_addr(r_ins.sa, cnt_idx);
            S_LDB:   rd_addr = f_addr(r_ins.sb, cnt_idx);
            default: rd_addr = f_addr(ecc_jpad_pkg::t_slot'(ecc_jpad_pkg::SL_RX
                                      + 5'(r_ocoord)), r_oidx);
        endcase
        mem_we = 1'b0;
        mem_wa = f_addr(r_ins.dst, cnt_idx);
        mem_wd = r_t[31:0];
        if (r_state == S_WB) begin
            mem_we = 1'b1;
        end else if (in_take && i_op == ecc_jpad_pkg::OP_LOAD
                     && i_target != ecc_jpad_pkg::TARGET_MOD && load_ok) begin
            mem_we = 1'b1;
            mem_wa = f_addr(ecc_jpad_pkg::t_slot'(5'(i_target) - 5'd1),
                            WIDX_W'(i_word_index));
            mem_wd = i_load_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n0 <= 32'd0;
        end else if (psel && penable && pwrite && paddr == ADDR_MONT_N0) begin
            r_n0 <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
            r_inf       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_az1 <= i_a_z_is_one;
                        r_bz1 <= i_b_z_is_one;
                        case (i_op)
                            ecc_jpad_pkg::OP_LOAD: begin
                                if (i_target == ecc_jpad_pkg::TARGET_MOD && load_ok) begin
                                    for (int k = 0; k < WORDS; k++) begin
                                        if (widx_ext == 32'(k)) begin
                                            r_mod[k*32 +: 32] <= i_load_word;
                                        end
                                    end
                                end
                            end
                            ecc_jpad_pkg::OP_ADD: begin
                                r_pc    <= ecc_jpad_pkg::PC_ADD;
                                r_state <= S_FETCH;
                            end
                            ecc_jpad_pkg::OP_DBL: begin
                                r_pc    <= ecc_jpad_pkg::PC_DBL;
                                r_state <= S_FETCH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_ins <= fetch_ins;
                    r_cnt <= '0;
                    r_ocoord <= 2'd0;
                    r_oidx <= '0;
                    if (!ecc_jpad_pkg::cond_ok(fetch_ins.cond, r_az1, r_bz1)) begin
                        r_pc <= r_pc + 1'b1;
                    end else begin
                        case (fetch_ins.kind)
                            ecc_jpad_pkg::K_BRA1: begin
                                if (r_z0 && r_z1) begin
                                    r_inf <= 1'b1;
                                    r_zone <= 1'b0;
                                    r_state <= S_ORD;
                                end else if (r_z0) begin
                                    r_pc <= ecc_jpad_pkg::PC_CPYB;
                                end else if (r_z1) begin
                                    r_pc <= ecc_jpad_pkg::PC_CPYA;
                                end else begin
                                    r_pc <= r_pc + 1'b1;
                                end
                            end
                            ecc_jpad_pkg::K_BRA2: begin
                                if (r_z0 && r_z1) begin
                                    r_pc <= ecc_jpad_pkg::PC_DBL;
                                end else if (r_z0) begin
                                    r_inf <= 1'b1;
                                    r_zone <= 1'b0;
                                    r_state <= S_ORD;
                                end else begin
                                    r_pc <= r_pc + 1'b1;
                                end
                            end
                            ecc_jpad_pkg::K_BRD: begin
                                if (r_z0) begin
                                    r_inf <= 1'b1;
                                    r_zone <= 1'b0;
                                    r_state <= S_ORD;
                                end else begin
                                    r_pc <= r_pc + 1'b1;
                                end
                            end
                            ecc_jpad_pkg::K_END: begin
                                r_inf <= 1'b0;
                                r_zone <= 1'b0;
                                r_state <= S_ORD;
                            end
                            ecc_jpad_pkg::K_ENDA: begin
                                r_inf <= 1'b0;
                                r_zone <= r_az1;
                                r_state <= S_ORD;
                            end
                            ecc_jpad_pkg::K_ENDB: begin
                                r_inf <= 1'b0;
                                r_zone <= r_bz1;
                                r_state <= S_ORD;
                            end
                            default: begin
                                r_state <= S_LDA;
                            end
                        endcase
                    end
                end
                S_LDA: begin
                    if (r_cnt != '0) begin
                        r_opa <= {r_rdata, r_opa[DW-1:32]};
                    end
                    if (r_cnt == CNT_W'(WORDS)) begin
                        r_cnt <= '0;
                        if (r_ins.kind == ecc_jpad_pkg::K_ADD || r_ins.kind == ecc_jpad_pkg::K_SUB
                            || r_ins.kind == ecc_jpad_pkg::K_MUL) begin
                            r_state <= S_LDB;
                        end else begin
                            r_state <= S_DISP;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_LDB: begin
                    if (r_cnt != '0) begin
                        r_opb <= {r_rdata, r_opb[DW-1:32]};
                    end
                    if (r_cnt == CNT_W'(WORDS)) begin
                        r_cnt <= '0;
                        r_state <= S_DISP;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DISP: begin
                    r_cnt <= '0;
                    r_c   <= 32'd0;
                    r_i   <= '0;
                    r_t   <= '0;
                    r_th  <= 32'd0;
                    r_th2 <= 1'b0;
                    case (r_ins.kind)
                        ecc_jpad_pkg::K_ZT: begin
                            if (r_ins.dst == ecc_jpad_pkg::FLAG1) begin
                                r_z1 <= (r_opa == '0);
                            end else begin
                                r_z0 <= (r_opa == '0);
                            end
                            r_pc <= r_pc + 1'b1;
                            r_state <= S_FETCH;
                        end
                        ecc_jpad_pkg::K_CPY: begin
                            r_t <= r_opa;
                            r_state <= S_WB;
                        end
                        ecc_jpad_pkg::K_ADD:  r_state <= S_ADD1;
                        ecc_jpad_pkg::K_SUB:  r_state <= S_SUB1;
                        ecc_jpad_pkg::K_HALF: r_state <= S_HALF1;
                        ecc_jpad_pkg::K_MUL:  r_state <= S_MULA;
                        default: begin
                            r_pc <= r_pc + 1'b1;
                            r_state <= S_FETCH;
                        end
                    endcase
                end
                S_ADD1: begin
                    {r_tc, r_t} <= add_sum;
                    r_state <= S_ADD2;
                end
                S_ADD2: begin
                    if (!red_dif[DW+1]) begin
                        r_t <= red_dif[DW-1:0];
                    end
                    r_state <= S_WB;
                end
                S_SUB1: begin
                    {r_tc, r_t} <= sub_dif;
                    r_state <= S_SUB2;
                end
                S_SUB2: begin
                    if (r_tc) begin
                        r_t <= r_t + r_mod;
                    end
                    r_state <= S_WB;
                end
                S_HALF1: begin
                    {r_tc, r_t} <= half_sum;
                    r_state <= S_HALF2;
                end
                S_HALF2: begin
                    r_t <= {r_tc, r_t[DW-1:1]};
                    r_state <= S_WB;
                end
                S_MULA: begin
                    r_t   <= {mac[31:0], r_t[DW-1:32]};
                    r_opa <= {r_opa[31:0], r_opa[DW-1:32]};
                    r_c   <= mac[63:32];
                    if (cnt_last) begin
                        r_state <= S_MULAH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MULAH: begin
                    r_th  <= hsum[31:0];
                    r_th2 <= hsum[32];
                    r_opb <= {r_opb[31:0], r_opb[DW-1:32]};
                    r_state <= S_MULM;
                end
                S_MULM: begin
                    r_m   <= prod[31:0];
                    r_pr  <= r_mod;
                    r_cnt <= '0;
                    r_c   <= 32'd0;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_t  <= {mac[31:0], r_t[DW-1:32]};
                    r_pr <= {r_pr[31:0], r_pr[DW-1:32]};
                    r_c  <= mac[63:32];
                    if (cnt_last) begin
                        r_state <= S_MULBH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MULBH: begin
                    r_t   <= {hsum[31:0], r_t[DW-1:32]};
                    r_th  <= 32'(r_th2) + 32'(hsum[32]);
                    r_th2 <= 1'b0;
                    r_cnt <= '0;
                    r_c   <= 32'd0;
                    if (r_i == WIDX_W'(WORDS - 1)) begin
                        r_state <= S_MULF;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_state <= S_MULA;
                    end
                end
                S_MULF: begin
                    if (r_th != 32'd0 || !fin_dif[DW]) begin
                        r_t <= fin_dif[DW-1:0];
                    end
                    r_cnt <= '0;
                    r_state <= S_WB;
                end
                S_WB: begin
                    r_t <= {r_t[31:0], r_t[DW-1:32]};
                    if (cnt_last) begin
                        r_pc <= r_pc + 1'b1;
                        r_state <= S_FETCH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ORD: begin
                    r_state <= S_OWAIT;
                end
                S_OWAIT: begin
                    r_out_word  <= r_inf ? 32'd0 : r_rdata;
                    r_out_coord <= r_ocoord;
                    r_out_idx   <= r_oidx;
                    r_out_last  <= (r_ocoord == 2'd2) && (r_oidx == WIDX_W'(WORDS - 1));
                    r_out_valid <= 1'b1;
                    r_state     <= S_OHOLD;
                end
                S_OHOLD: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            if (r_oidx == WIDX_W'(WORDS - 1)) begin
                                r_oidx <= '0;
                                r_ocoord <= r_ocoord + 2'd1;
                            end else begin
                                r_oidx <= r_oidx + 1'b1;
                            end
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_state == S_OHOLD)
        else $error("result valid outside output hold");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && (i_op == ecc_jpad_pkg::OP_ADD || i_op == ecc_jpad_pkg::OP_DBL))
        |=> o_in_stall)
        else $error("run transaction did not block input");

    a_last_is_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_last) |-> (o_coordinate == 2'd2))
        else $error("last word not on z coordinate");

    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_inf) |-> (o_result_word == 32'd0 && !o_result_z_is_one))
        else $error("infinity result not zero");

endmodule
